/* rtl/spn_pkg.sv */
// Shared types and constants of the shortest-process-next scheduler.
package spn_pkg;

  localparam int unsigned MAX_PROCS_DEF = 64;
  localparam int unsigned ID_W          = 8;
  localparam int unsigned ARR_W         = 16;
  localparam int unsigned SVC_W         = 16;
  localparam int unsigned TIME_W        = 23;
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  // Request: one process of the list.
  typedef struct packed {
    logic [ID_W-1:0]  proc_id;
    logic [ARR_W-1:0] arrive_at;
    logic [SVC_W-1:0] burst_len;
    logic             last_process;
  } spn_in_t;

  // Result record: one per scheduled process.
  typedef struct packed {
    logic [ID_W-1:0]   done_id;
    logic [TIME_W-1:0] dispatch_at;
    logic [TIME_W-1:0] finish_time;
    logic [TIME_W-1:0] wait_len;
    logic [TIME_W-1:0] turnaround_len;
    logic              dropped_some;
    logic              last_result;
  } spn_out_t;

  // Process table entry; the finished mark lives beside the payload.
  typedef struct packed {
    logic             done_flag;
    logic [ID_W-1:0]  id;
    logic [ARR_W-1:0] arr;
    logic [SVC_W-1:0] svc;
  } spn_ent_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DISPATCH,
    ST_TAT,
    ST_EMIT
  } spn_state_t;

endpackage

/* rtl/shortest_process_next_scheduler.sv */
// Top level: non-preemptive shortest-process-next scheduler.
//
// Usage: processes are loaded one request at a time on in_req, accepted at
// a rising edge with start high and busy low. Each request is one process
// (id, arrival, service time); the request with last_process set ends the
// list and starts scheduling. Non-last requests give no
// result. Requests beyond MAX_PROCS are not stored but set dropped_some on
// every record of that list; a dropped last request still schedules.
// Scheduling: per dispatch the whole table of n loaded processes is scanned
// through the single read port of the process memory, picking the shortest
// arrived job (ties to the earlier-loaded one), or else the earliest
// pending arrival. Each record takes the n table reads, a wait for the last
// registered read, a step to close the scan, then dispatch, turnaround
// and emit. busy is high while the list is scheduled.
// Results: one record per process in run order on out_rec, with out_valid
// high for exactly one cycle; the receiver cannot stall the block.
// Reset (rst_n low, synchronous) returns to idle with an empty list. The
// process memory is not cleared: only loaded entries are read, and the
// finished mark is written with each entry.
module shortest_process_next_scheduler
  import spn_pkg::*;
#(
  parameter int unsigned MAX_PROCS = MAX_PROCS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  spn_in_t  in_req,
  output logic     out_valid,
  output spn_out_t out_rec
);

  localparam int unsigned AW = $clog2(MAX_PROCS);
  localparam int unsigned CW = $clog2(MAX_PROCS + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_PROCS);

  // Process table: one write port, one registered read port.
  spn_ent_t mem [MAX_PROCS];
  spn_ent_t rd_data_r;
  logic          rd_en, we;
  logic [AW-1:0] rd_addr, wr_addr;
  spn_ent_t      wr_data;

  // Control state
  spn_state_t    state_r, state_nxt;
  logic [CW-1:0] load_cnt_r, load_cnt_nxt;
  logic          ovf_r, ovf_nxt;
  logic [CW-1:0] scan_cnt_r, scan_cnt_nxt;
  logic          rd_vld_r, rd_vld_nxt;
  logic [CW-1:0] done_cnt_r, done_cnt_nxt;
  logic          have_pick_r, have_pick_nxt;
  logic          have_early_r, have_early_nxt;
  logic          out_valid_r, out_valid_nxt;

  // Datapath
  logic [AW-1:0]     rd_idx_r, rd_idx_nxt;
  logic [ARR_W-1:0]  first_arr_r, first_arr_nxt;
  logic [TIME_W-1:0] clock_r, clock_nxt;
  spn_ent_t          pick_r, pick_nxt;
  logic [AW-1:0]     pick_idx_r, pick_idx_nxt;
  spn_ent_t          early_r, early_nxt;
  logic [AW-1:0]     early_idx_r, early_idx_nxt;
  spn_ent_t          sel_r, sel_nxt;
  logic [TIME_W-1:0] start_r, start_nxt;
  logic [TIME_W-1:0] fin_r, fin_nxt;
  logic [TIME_W-1:0] tat_r, tat_nxt;
  spn_out_t          out_rec_r, out_rec_nxt;

  logic              accept;
  logic              eligible, pending;
  logic [TIME_W-1:0] clock_sel;
  logic [TIME_W:0]   fin_sum;
  logic [TIME_W-1:0] svc_ext;
  logic [CW-1:0]     done_inc;

  assign accept    = start && (state_r == ST_IDLE);
  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_rec   = out_rec_r;

  // Table write/read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_comb begin
    state_nxt      = state_r;
    load_cnt_nxt   = load_cnt_r;
    ovf_nxt        = ovf_r;
    scan_cnt_nxt   = scan_cnt_r;
    rd_vld_nxt     = 1'b0;
    done_cnt_nxt   = done_cnt_r;
    have_pick_nxt  = have_pick_r;
    have_early_nxt = have_early_r;
    out_valid_nxt  = 1'b0;
    rd_idx_nxt     = rd_idx_r;
    first_arr_nxt  = first_arr_r;
    clock_nxt      = clock_r;
    pick_nxt       = pick_r;
    pick_idx_nxt   = pick_idx_r;
    early_nxt      = early_r;
    early_idx_nxt  = early_idx_r;
    sel_nxt        = sel_r;
    start_nxt      = start_r;
    fin_nxt        = fin_r;
    tat_nxt        = tat_r;
    out_rec_nxt    = out_rec_r;
    rd_en          = 1'b0;
    rd_addr        = scan_cnt_r[AW-1:0];
    we             = 1'b0;
    wr_addr        = load_cnt_r[AW-1:0];
    wr_data        = '0;
    eligible       = 1'b0;
    pending        = 1'b0;
    clock_sel      = have_pick_r ? clock_r : TIME_W'(early_r.arr);
    svc_ext        = have_pick_r ? TIME_W'(pick_r.svc) : TIME_W'(early_r.svc);
    fin_sum        = {1'b0, clock_sel} + {1'b0, svc_ext};
    done_inc       = done_cnt_r + CW'(1);

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (load_cnt_r < CNT_MAX) begin
            we      = 1'b1;
            wr_data = '{done_flag: 1'b0, id: in_req.proc_id,
                        arr: in_req.arrive_at, svc: in_req.burst_len};
            load_cnt_nxt = load_cnt_r + CW'(1);
            if (load_cnt_r == '0) begin
              first_arr_nxt = in_req.arrive_at;
            end
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_req.last_process) begin
            // clock starts at the first loaded arrival
            clock_nxt      = (load_cnt_r == '0) ? TIME_W'(in_req.arrive_at)
                                                : TIME_W'(first_arr_r);
            done_cnt_nxt   = '0;
            scan_cnt_nxt   = '0;
            have_pick_nxt  = 1'b0;
            have_early_nxt = 1'b0;
            state_nxt      = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        if (scan_cnt_r < load_cnt_r) begin
          rd_en        = 1'b1;
          rd_vld_nxt   = 1'b1;
          rd_idx_nxt   = scan_cnt_r[AW-1:0];
          scan_cnt_nxt = scan_cnt_r + CW'(1);
        end else if (!rd_vld_r) begin
          state_nxt = ST_DISPATCH;
        end
        if (rd_vld_r) begin
          eligible = !rd_data_r.done_flag && (TIME_W'(rd_data_r.arr) <= clock_r);
          pending  = !rd_data_r.done_flag;
          if (eligible && (!have_pick_r || (rd_data_r.svc < pick_r.svc))) begin
            have_pick_nxt = 1'b1;
            pick_nxt      = rd_data_r;
            pick_idx_nxt  = rd_idx_r;
          end
          // earliest pending arrival, shortest job within that arrival
          if (pending && (!have_early_r || (rd_data_r.arr < early_r.arr) ||
              ((rd_data_r.arr == early_r.arr) && (rd_data_r.svc < early_r.svc)))) begin
            have_early_nxt = 1'b1;
            early_nxt      = rd_data_r;
            early_idx_nxt  = rd_idx_r;
          end
        end
      end

      ST_DISPATCH: begin
        sel_nxt   = have_pick_r ? pick_r : early_r;
        start_nxt = clock_sel;
        fin_nxt   = fin_sum[TIME_W] ? TIME_MAX : fin_sum[TIME_W-1:0];
        we        = 1'b1;
        wr_addr   = have_pick_r ? pick_idx_r : early_idx_r;
        wr_data   = have_pick_r ? pick_r : early_r;
        wr_data.done_flag = 1'b1;
        state_nxt = ST_TAT;
      end

      ST_TAT: begin
        tat_nxt   = fin_r - TIME_W'(sel_r.arr);
        clock_nxt = fin_r;
        state_nxt = ST_EMIT;
      end

      ST_EMIT: begin
        out_valid_nxt              = 1'b1;
        out_rec_nxt.done_id        = sel_r.id;
        out_rec_nxt.dispatch_at    = start_r;
        out_rec_nxt.finish_time    = fin_r;
        out_rec_nxt.turnaround_len = tat_r;
        out_rec_nxt.wait_len       = (tat_r >= TIME_W'(sel_r.svc))
                                     ? tat_r - TIME_W'(sel_r.svc) : '0;
        out_rec_nxt.dropped_some   = ovf_r;
        out_rec_nxt.last_result    = (done_inc == load_cnt_r);
        done_cnt_nxt               = done_inc;
        scan_cnt_nxt               = '0;
        have_pick_nxt              = 1'b0;
        have_early_nxt             = 1'b0;
        if (done_inc == load_cnt_r) begin
          // list finished: back to an empty table
          load_cnt_nxt = '0;
          done_cnt_nxt = '0;
          ovf_nxt      = 1'b0;
          clock_nxt    = '0;
          state_nxt    = ST_IDLE;
        end else begin
          state_nxt = ST_SCAN;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      load_cnt_r   <= '0;
      ovf_r        <= 1'b0;
      scan_cnt_r   <= '0;
      rd_vld_r     <= 1'b0;
      done_cnt_r   <= '0;
      have_pick_r  <= 1'b0;
      have_early_r <= 1'b0;
      out_valid_r  <= 1'b0;
      clock_r      <= '0;
    end else begin
      state_r      <= state_nxt;
      load_cnt_r   <= load_cnt_nxt;
      ovf_r        <= ovf_nxt;
      scan_cnt_r   <= scan_cnt_nxt;
      rd_vld_r     <= rd_vld_nxt;
      done_cnt_r   <= done_cnt_nxt;
      have_pick_r  <= have_pick_nxt;
      have_early_r <= have_early_nxt;
      out_valid_r  <= out_valid_nxt;
      clock_r      <= clock_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    rd_idx_r    <= rd_idx_nxt;
    first_arr_r <= first_arr_nxt;
    pick_r      <= pick_nxt;
    pick_idx_r  <= pick_idx_nxt;
    early_r     <= early_nxt;
    early_idx_r <= early_idx_nxt;
    sel_r       <= sel_nxt;
    start_r     <= start_nxt;
    fin_r       <= fin_nxt;
    tat_r       <= tat_nxt;
    out_rec_r   <= out_rec_nxt;
  end

  // Records are single-cycle strobes, separated by at least a full scan.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  a_fin_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_rec.finish_time >= out_rec.dispatch_at))
    else $error("finish before start");

  a_wait_le_tat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_rec.wait_len <= out_rec.turnaround_len))
    else $error("waiting exceeds turnaround");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (load_cnt_r <= CNT_MAX) && (done_cnt_r <= load_cnt_r))
    else $error("table count out of range");

  a_dispatch_has_candidate: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DISPATCH) |-> (have_pick_r || have_early_r))
    else $error("dispatch without a candidate");

endmodule

/* tb/shortest_process_next_scheduler_test.sv */
// Self-checking testbench of the shortest-process-next scheduler.
module shortest_process_next_scheduler_test
  import spn_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP = MAX_PROCS_DEF;

  // One planned request: the payload, the idle cycles in front of it, and
  // whether the sender must first see every outstanding record arrive.
  typedef struct {
    spn_in_t     req;
    int unsigned gap;
    bit          drain;
  } planned_req_t;

  logic     clk;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  spn_in_t  in_req = '0;
  logic     busy;
  logic     out_valid;
  spn_out_t out_rec;

  planned_req_t request_q[$];
  spn_out_t     record_q[$];
  int           requests_planned = 0;
  int           requests_sent = 0;
  int           error_count = 0;
  int unsigned  idle_count = 0;

  // Shadow of the process table held by the block.
  logic [ID_W-1:0]  tab_id   [CAP];
  logic [ARR_W-1:0] tab_arr  [CAP];
  logic [SVC_W-1:0] tab_svc  [CAP];
  bit               tab_done [CAP];
  int               n_loaded = 0;
  bit               lost_some = 1'b0;

  shortest_process_next_scheduler uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_rec  (out_rec)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Single reset pulse at the start of the run.
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Shortest job among those arrived by 'now' and not yet run; a tie keeps
  // the earlier-loaded entry because only a strictly shorter one replaces it.
  function automatic int shortest_arrived(input int unsigned now);
    int pick = -1;
    for (int i = 0; i < n_loaded; i++) begin
      if (!tab_done[i] && tab_arr[i] <= now && (pick < 0 || tab_svc[i] < tab_svc[pick]))
        pick = i;
    end
    return pick;
  endfunction

  // Takes one accepted request into the shadow table. A request marked last
  // plays out the whole schedule and queues one record per stored process.
  task automatic schedule_request(input spn_in_t req);
    int unsigned now, fin, tat, queued;
    int          pick, early;
    spn_out_t    rec;
    if (n_loaded < CAP) begin
      tab_id[n_loaded]   = req.proc_id;
      tab_arr[n_loaded]  = req.arrive_at;
      tab_svc[n_loaded]  = req.burst_len;
      tab_done[n_loaded] = 1'b0;
      n_loaded++;
    end else begin
      // table full: request dropped, but a last flag still counts
      lost_some = 1'b1;
    end
    if (req.last_process) begin
      // the clock starts at the first loaded arrival, sorted or not
      now = 32'(tab_arr[0]);
      for (int k = 0; k < n_loaded; k++) begin
        pick = shortest_arrived(now);
        if (pick < 0) begin
          // idle CPU: jump forward to the earliest pending arrival
          early = -1;
          for (int i = 0; i < n_loaded; i++) begin
            if (!tab_done[i] && (early < 0 || tab_arr[i] < tab_arr[early]))
              early = i;
          end
          now  = 32'(tab_arr[early]);
          pick = shortest_arrived(now);
        end
        fin = now + 32'(tab_svc[pick]);
        if (fin > 32'(TIME_MAX)) fin = 32'(TIME_MAX);
        tat    = fin - 32'(tab_arr[pick]);
        queued = (tat >= 32'(tab_svc[pick])) ? tat - 32'(tab_svc[pick]) : 0;
        rec.done_id        = tab_id[pick];
        rec.dispatch_at    = TIME_W'(now);
        rec.finish_time    = TIME_W'(fin);
        rec.wait_len       = TIME_W'(queued);
        rec.turnaround_len = TIME_W'(tat);
        rec.dropped_some   = lost_some;
        rec.last_result    = (k == n_loaded - 1);
        record_q.push_back(rec);
        tab_done[pick] = 1'b1;
        now = fin;
      end
      n_loaded  = 0;
      lost_some = 1'b0;
    end
  endtask

  task automatic queue_request(input logic [ID_W-1:0] id, input logic [ARR_W-1:0] arr,
                               input logic [SVC_W-1:0] svc, input bit last,
                               input int unsigned gap, input bit drain);
    planned_req_t p;
    p.req.proc_id      = id;
    p.req.arrive_at    = arr;
    p.req.burst_len    = svc;
    p.req.last_process = last;
    p.gap   = gap;
    p.drain = drain;
    request_q.push_back(p);
    requests_planned++;
  endtask

  // One list of n processes. Arrival pattern, service spread and pacing
  // are drawn per list so that bursts, ties and idle jumps all turn up.
  task automatic queue_random_list(input int n);
    int unsigned arr, svc, arr_mode, svc_mode;
    bit          burst, drain;
    arr_mode = $urandom_range(0, 5);  // 0: unsorted, 1: sparse jumps, else dense
    svc_mode = $urandom_range(0, 2);  // 0: short with ties, 1: full range, 2: mixed
    burst    = ($urandom_range(0, 2) == 0);
    drain    = ($urandom_range(0, 5) == 0);
    arr      = $urandom_range(0, 65535);
    for (int k = 0; k < n; k++) begin
      if (arr_mode == 0)
        arr = $urandom_range(0, 65535);
      else if (arr_mode == 1 && $urandom_range(0, 3) == 0)
        arr += $urandom_range(0, 6000);
      else
        arr += $urandom_range(0, 12);
      if (arr > 65535) arr = 65535;
      case (svc_mode)
        0:       svc = $urandom_range(1, 16);
        1:       svc = $urandom_range(1, 65535);
        default: svc = $urandom_range(0, 1) ? $urandom_range(1, 40)
                                            : $urandom_range(1, 65535);
      endcase
      if ($urandom_range(0, 49) == 0) svc = 0;
      queue_request(ID_W'($urandom_range(0, 255)), ARR_W'(arr), SVC_W'(svc), k == n - 1,
                    burst ? 0 : $urandom_range(0, 9), drain && k == 0);
    end
  endtask

  // Driver: a request is accepted on an edge with start high and busy low.
  // The next request may go straight out on that same edge, so start gets a
  // single nonblocking update per edge.
  always @(posedge clk) begin
    logic launch;
    launch = 1'b0;
    if (!rst_n) begin
      start <= 1'b0;
      idle_count = 0;
    end else begin
      if (start && !busy) begin
        schedule_request(in_req);
        requests_sent++;
      end
      if ((!start || !busy) && request_q.size() > 0) begin
        if (idle_count < request_q[0].gap)
          idle_count++;
        else if (!request_q[0].drain || record_q.size() == 0)
          launch = 1'b1;
      end
      if (launch) begin
        in_req <= request_q[0].req;
        void'(request_q.pop_front());
        idle_count = 0;
      end
      start <= launch ? 1'b1 : (start && busy);
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  // Monitor: a record is valid for one cycle only and cannot be held off.
  always @(posedge clk) begin
    spn_out_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (record_q.size() == 0) begin
        $error("done_id: expected no record, got %0d", out_rec.done_id);
        error_count++;
      end else begin
        want = record_q.pop_front();
        check_field("done_id", 32'(want.done_id), 32'(out_rec.done_id));
        check_field("dispatch_at", 32'(want.dispatch_at), 32'(out_rec.dispatch_at));
        check_field("finish_time", 32'(want.finish_time), 32'(out_rec.finish_time));
        check_field("wait_len", 32'(want.wait_len), 32'(out_rec.wait_len));
        check_field("turnaround_len", 32'(want.turnaround_len),
                    32'(out_rec.turnaround_len));
        check_field("dropped_some", 32'(want.dropped_some), 32'(out_rec.dropped_some));
        check_field("last_result", 32'(want.last_result), 32'(out_rec.last_result));
      end
    end
  end

  initial begin
    // Directed lists.
    // lone process at the top of every field
    queue_request(8'hFF, 16'hFFFF, 16'hFFFF, 1'b1, 0, 1'b0);
    // lone process at the bottom; sender first waits for the previous record
    queue_request(8'h00, 16'h0000, 16'h0001, 1'b1, 0, 1'b1);
    // all arrive together: shortest first, equal services in load order
    queue_request(8'd11, 16'd0, 16'd5, 1'b0, 0, 1'b0);
    queue_request(8'd12, 16'd0, 16'd3, 1'b0, 0, 1'b0);
    queue_request(8'd13, 16'd0, 16'd3, 1'b1, 0, 1'b0);
    // CPU runs dry: clock jumps forward to the next arrival
    queue_request(8'd21, 16'd10, 16'd4, 1'b0, 3, 1'b1);
    queue_request(8'd22, 16'd100, 16'd2, 1'b0, 2, 1'b0);
    queue_request(8'd23, 16'd101, 16'd1, 1'b1, 1, 1'b0);
    // arrivals out of order: clock starts at the first loaded arrival
    queue_request(8'd31, 16'd50, 16'd8, 1'b0, 0, 1'b0);
    queue_request(8'd32, 16'd20, 16'd3, 1'b0, 0, 1'b0);
    queue_request(8'd33, 16'd60, 16'd1, 1'b0, 0, 1'b0);
    queue_request(8'd34, 16'd0, 16'd2, 1'b1, 0, 1'b0);
    // zero service time
    queue_request(8'd41, 16'd5, 16'd0, 1'b0, 5, 1'b0);
    queue_request(8'd42, 16'd5, 16'd0, 1'b0, 9, 1'b0);
    queue_request(8'd43, 16'd7, 16'd9, 1'b1, 0, 1'b0);
    // no preemption: a long job keeps the CPU while shorter ones arrive
    queue_request(8'd51, 16'd0, 16'd100, 1'b0, 0, 1'b0);
    queue_request(8'd52, 16'd1, 16'd50, 1'b0, 0, 1'b0);
    queue_request(8'd53, 16'd2, 16'd10, 1'b1, 0, 1'b0);

    // Random lists: one exactly full, one overflowing by two (the dropped
    // last request still starts the schedule), then mostly short lists.
    queue_random_list(CAP);
    queue_random_list(CAP + 2);
    while (requests_planned < 250)
      queue_random_list(($urandom_range(0, 7) == 0) ? $urandom_range(9, 24)
                                                    : $urandom_range(1, 8));

    do @(posedge clk); while (requests_sent < requests_planned);
    while (record_q.size() != 0) @(posedge clk);
    // allow for any stray record after the last expected one
    repeat (100) @(posedge clk);
    if (error_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
